// File: src/opp_pkg.sv
// Shared types, codes and constants for the OBD-II PID poller.
// Used by opp_reply_decode, opp_core and obd2_pid_poller_unit; no dependencies.
package opp_pkg;

   localparam int ID_W   = 11;
   localparam int DATA_W = 64;
   localparam int TIME_W = 32;
   localparam int RPM_W  = 14;
   localparam int SPD_W  = 8;
   localparam int COOL_W = 9;
   localparam int OIL_W  = 11;

   localparam logic [ID_W-1:0] REQUEST_ID_RESET = 11'h7DF;

   localparam logic [1:0] ACT_SEND    = 2'd0;
   localparam logic [1:0] ACT_REPLY   = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RECORD  = 1'b1;

   localparam logic [7:0] SVC_CURRENT_ACK = 8'h41;
   localparam logic [7:0] SVC_BY_ID_ACK   = 8'h62;
   localparam logic [7:0] PID_RPM         = 8'h0C;
   localparam logic [7:0] PID_SPEED       = 8'h0D;
   localparam logic [7:0] PID_COOLANT     = 8'h05;
   localparam logic [7:0] OIL_ID_HI       = 8'h13;
   localparam logic [7:0] OIL_ID_LO       = 8'h10;

   localparam logic [DATA_W-1:0] REQ_RPM     = 64'hCCCC_CCCC_CC0C_0102;
   localparam logic [DATA_W-1:0] REQ_SPEED   = 64'hCCCC_CCCC_CC0D_0102;
   localparam logic [DATA_W-1:0] REQ_COOLANT = 64'hCCCC_CCCC_CC05_0102;
   localparam logic [DATA_W-1:0] REQ_OIL     = 64'hCCCC_CCCC_1013_2203;

   localparam logic [COOL_W-1:0] COOL_OFFSET = 9'd40;
   localparam logic [OIL_W-1:0]  OIL_OFFSET  = 11'd40;
   // floor(x / 100) == (x * 83887) >> 23 for every 16-bit x
   localparam logic [16:0] DIV100_MUL   = 17'd83887;
   localparam int          DIV100_SHIFT = 23;

   typedef enum logic [2:0] {
      PH_RPM     = 3'd0,
      PH_SPEED   = 3'd1,
      PH_COOLANT = 3'd2,
      PH_OIL     = 3'd3,
      PH_PUBLISH = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [DATA_W-1:0] rx_payload;
      logic [TIME_W-1:0] time_now;
   } item_type;

   typedef struct packed {
      logic                     upd_rpm;
      logic                     upd_speed;
      logic                     upd_coolant;
      logic                     upd_oil;
      logic [RPM_W-1:0]         rpm;
      logic [SPD_W-1:0]         speed;
      logic signed [COOL_W-1:0] coolant;
      logic signed [OIL_W-1:0]  oil;
   } decode_type;

   typedef struct packed {
      logic                     result_kind;
      logic [ID_W-1:0]          frame_id;
      logic [DATA_W-1:0]        frame_payload;
      logic [RPM_W-1:0]         engine_rpm;
      logic [SPD_W-1:0]         vehicle_speed;
      logic signed [COOL_W-1:0] coolant_deg;
      logic signed [OIL_W-1:0]  oil_deg;
      logic [TIME_W-1:0]        record_time;
   } result_type;

   function automatic logic [DATA_W-1:0] request_payload(input phase_type ph);
      logic [DATA_W-1:0] p;
      unique case (ph)
         PH_RPM:     p = REQ_RPM;
         PH_SPEED:   p = REQ_SPEED;
         PH_COOLANT: p = REQ_COOLANT;
         PH_OIL:     p = REQ_OIL;
         default:    p = '0;
      endcase
      return p;
   endfunction

endpackage

// File: src/opp_reply_decode.sv
// Reply frame decoder: matches the reply against the current query phase
// and scales the data bytes. Depends on opp_pkg.
module opp_reply_decode import opp_pkg::*; (
   input  phase_type         phase,
   input  logic [DATA_W-1:0] rx_payload,
   output decode_type        dec
);

   logic [7:0]  b1, b2, b3, b4, b5;
   logic [15:0] oil_raw;
   logic [32:0] oil_prod;
   logic [9:0]  oil_quot;

   assign b1 = rx_payload[15:8];
   assign b2 = rx_payload[23:16];
   assign b3 = rx_payload[31:24];
   assign b4 = rx_payload[39:32];
   assign b5 = rx_payload[47:40];

   assign oil_raw  = {b4, b5};
   assign oil_prod = 33'(oil_raw) * 33'(DIV100_MUL);
   assign oil_quot = oil_prod[DIV100_SHIFT +: 10];

   always_comb begin
      dec.upd_rpm     = 1'b0;
      dec.upd_speed   = 1'b0;
      dec.upd_coolant = 1'b0;
      dec.upd_oil     = 1'b0;
      dec.rpm         = {b3, b4[7:2]};
      dec.speed       = b3;
      dec.coolant     = {1'b0, b3} - COOL_OFFSET;
      dec.oil         = {1'b0, oil_quot} - OIL_OFFSET;
      unique case (phase)
         PH_RPM:     dec.upd_rpm     = (b1 == SVC_CURRENT_ACK) && (b2 == PID_RPM);
         PH_SPEED:   dec.upd_speed   = (b1 == SVC_CURRENT_ACK) && (b2 == PID_SPEED);
         PH_COOLANT: dec.upd_coolant = (b1 == SVC_CURRENT_ACK) && (b2 == PID_COOLANT);
         PH_OIL:     dec.upd_oil     = (b1 == SVC_BY_ID_ACK) && (b2 == OIL_ID_HI)
                                       && (b3 == OIL_ID_LO);
         default: begin
         end
      endcase
   end

endmodule

// File: src/opp_core.sv
// Poller sequencer: phase and wait state, stored readings and the result
// register. Depends on opp_pkg and opp_reply_decode.
module opp_core import opp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_ready,
   input  logic [ID_W-1:0] request_id,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output result_type      rsp_result
);

   phase_type                phase_ff, phase_in;
   logic                     awaiting_ff, awaiting_in;
   logic [RPM_W-1:0]         rpm_ff, rpm_in;
   logic [SPD_W-1:0]         speed_ff, speed_in;
   logic signed [COOL_W-1:0] coolant_ff, coolant_in;
   logic signed [OIL_W-1:0]  oil_ff, oil_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               result_ff, result_in;

   decode_type dec;
   phase_type  phase_next;
   logic       advance, take, is_send, is_end, emit;
   result_type built;

   opp_reply_decode u_decode (
      .phase      (phase_ff),
      .rx_payload (item.rx_payload),
      .dec        (dec)
   );

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign take       = item_valid && advance;
   assign is_send    = (item.action == ACT_SEND);
   assign is_end     = (item.action == ACT_REPLY) || (item.action == ACT_TIMEOUT);
   assign item_ready = advance;

   always_comb begin
      unique case (phase_ff)
         PH_RPM:     phase_next = PH_SPEED;
         PH_SPEED:   phase_next = PH_COOLANT;
         PH_COOLANT: phase_next = PH_OIL;
         PH_OIL:     phase_next = PH_PUBLISH;
         default:    phase_next = PH_RPM;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      awaiting_in = awaiting_ff;
      rpm_in      = rpm_ff;
      speed_in    = speed_ff;
      coolant_in  = coolant_ff;
      oil_in      = oil_ff;
      emit        = 1'b0;
      built       = '0;
      if (take && is_send && !awaiting_ff) begin
         emit = 1'b1;
         if (phase_ff == PH_RPM || phase_ff == PH_SPEED || phase_ff == PH_COOLANT
             || phase_ff == PH_OIL) begin
            built.result_kind   = KIND_REQUEST;
            built.frame_id      = request_id;
            built.frame_payload = request_payload(phase_ff);
            awaiting_in         = 1'b1;
         end else begin
            built.result_kind   = KIND_RECORD;
            built.engine_rpm    = rpm_ff;
            built.vehicle_speed = speed_ff;
            built.coolant_deg   = coolant_ff;
            built.oil_deg       = oil_ff;
            built.record_time   = item.time_now;
            phase_in            = PH_RPM;
         end
      end else if (take && is_end && awaiting_ff) begin
         if (item.action == ACT_REPLY) begin
            if (dec.upd_rpm)     rpm_in     = dec.rpm;
            if (dec.upd_speed)   speed_in   = dec.speed;
            if (dec.upd_coolant) coolant_in = dec.coolant;
            if (dec.upd_oil)     oil_in     = dec.oil;
         end
         awaiting_in = 1'b0;
         phase_in    = phase_next;
      end
      rsp_valid_in = advance ? emit : rsp_valid_ff;
      result_in    = emit ? built : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RPM;
         awaiting_ff  <= 1'b0;
         rpm_ff       <= '0;
         speed_ff     <= '0;
         coolant_ff   <= '0;
         oil_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         awaiting_ff  <= awaiting_in;
         rpm_ff       <= rpm_in;
         speed_ff     <= speed_in;
         coolant_ff   <= coolant_in;
         oil_ff       <= oil_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   a_wait_in_query: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> (phase_ff != PH_PUBLISH))
      else $error("waiting for a reply in the publish phase");

   a_request_sets_wait: assert property (@(posedge clock) disable iff (reset)
      (take && is_send && !awaiting_ff && phase_ff != PH_PUBLISH) |=> awaiting_ff)
      else $error("request issued without entering the wait");

   a_record_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && is_send && !awaiting_ff && phase_ff == PH_PUBLISH)
      |=> (phase_ff == PH_RPM && rsp_valid_ff && result_ff.result_kind == KIND_RECORD))
      else $error("record not published or phase not restarted");

   a_end_clears_wait: assert property (@(posedge clock) disable iff (reset)
      (take && is_end && awaiting_ff) |=> (!awaiting_ff && phase_ff != PH_RPM))
      else $error("reply or timeout did not end the wait");

endmodule

// File: src/obd2_pid_poller_unit.sv
// A word on req_ is held in the input register, its result in the output register.
// Throughput: one word per cycle; the input register refills while a result
// waits in the output register, stalls only when both are held.
// Reset: phase returns to rpm query, wait flag and stored readings clear,
// request_id returns to 0x7DF. Top level of the poller; depends on opp_pkg, opp_core.
module obd2_pid_poller_unit import opp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // rx_payload[63:0], time_now[95:64]
   input  logic [1:0]   req_tuser,   // action[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // frame_id, frame_payload, engine_rpm,
                                     // vehicle_speed, coolant_deg, oil_deg,
                                     // record_time, zero pad
   output logic [0:0]   rsp_tuser,   // result_kind
   input  logic         csr_tvalid,
   output logic         csr_tready,
   input  logic [15:0]  csr_tdata    // request_id[10:0], unused[15:11]
);

   logic            s1_valid_ff, s1_valid_in;
   item_type        s1_item_ff, s1_item_in;
   logic [ID_W-1:0] request_id_ff, request_id_in;
   logic            core_ready;
   result_type      res;

   assign req_tready = !s1_valid_ff || core_ready;
   assign csr_tready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_tready) begin
         s1_valid_in           = req_tvalid;
         s1_item_in.action     = req_tuser;
         s1_item_in.rx_payload = req_tdata[63:0];
         s1_item_in.time_now   = req_tdata[95:64];
      end
      request_id_in = (csr_tvalid && csr_tready) ? csr_tdata[ID_W-1:0] : request_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         request_id_ff <= REQUEST_ID_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         request_id_ff <= request_id_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   opp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .item_ready (core_ready),
      .request_id (request_id_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (res)
   );

   assign rsp_tuser = res.result_kind;
   assign rsp_tdata = {3'b000, res.record_time, res.oil_deg, res.coolant_deg,
                       res.vehicle_speed, res.engine_rpm, res.frame_payload,
                       res.frame_id};

endmodule
